/* rtl/dhcp_lease_pkg.sv */
// Package for the DHCP client lease engine: word types, phase, action and error codes.
// Used by dhcp_client_lease_engine_top.
`default_nettype none
package dhcp_lease_pkg;
  localparam int unsigned MaxPayloadBytes = 1024;
  localparam logic [31:0] Cookie = 32'h63825363;

  typedef enum logic [1:0] {
    ActByte    = 2'd0,
    ActTick    = 2'd1,
    ActStart   = 2'd2,
    ActRelease = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    SendNone     = 2'd0,
    SendDiscover = 2'd1,
    SendRequest  = 2'd2,
    SendRelease  = 2'd3
  } send_e;

  localparam logic [2:0] PhInit   = 3'd0;
  localparam logic [2:0] PhDisc   = 3'd1;
  localparam logic [2:0] PhReq    = 3'd2;
  localparam logic [2:0] PhBound  = 3'd3;
  localparam logic [2:0] PhRenew  = 3'd4;
  localparam logic [2:0] PhRebind = 3'd5;

  localparam logic [2:0] ErrNone   = 3'd0;
  localparam logic [2:0] ErrCookie = 3'd1;
  localparam logic [2:0] ErrOp     = 3'd2;
  localparam logic [2:0] ErrXid    = 3'd3;
  localparam logic [2:0] ErrFirst  = 3'd4;
  localparam logic [2:0] ErrType   = 3'd5;
  localparam logic [2:0] ErrOffer  = 3'd6;
  localparam logic [2:0] ErrShort  = 3'd7;

  localparam logic [1:0] WkCode = 2'd0;
  localparam logic [1:0] WkLen  = 2'd1;
  localparam logic [1:0] WkData = 2'd2;
  localparam logic [1:0] WkDone = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  send_kind;
    logic [2:0]  phase;
    logic [2:0]  error_code;
    logic [31:0] ip_addr;
    logic [31:0] net_mask;
    logic [31:0] gateway_addr;
    logic [31:0] server_addr;
    logic [31:0] lease_seconds;
  } out_word_t;
endpackage
`default_nettype wire

/* rtl/dhcp_client_lease_engine_top.sv */
// DHCP client lease engine, top level. Depends on dhcp_lease_pkg.
// Holds the reply parser, lease timers and the output word register.
`default_nettype none
// One input word per cycle: each word is registered, processed by one level of logic and the
// result word lands in an output register; stall on the output only stalls the input when the
// output register is still full and not being taken.
// Reply bytes, ticks and commands may interleave freely. Renew and rebind deadlines
// (floor t/2, floor 7t/8) are computed once when an ack is committed and held in registers.
module dhcp_client_lease_engine_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [31:0]               cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire dhcp_lease_pkg::in_word_t  in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output dhcp_lease_pkg::out_word_t      out_data_o
);
  import dhcp_lease_pkg::*;

  logic [31:0] xid_q;
  logic        iv_q;
  in_word_t    iw_q;
  logic        ov_q;
  out_word_t   ow_q, ow_d;

  logic [2:0]  phase_q, phase_d;
  logic [15:0] off_q, off_d;
  logic [1:0]  wpos_q, wpos_d;
  logic [7:0]  wcode_q, wcode_d, wlen_q, wlen_d;
  logic [7:0]  widx_q, widx_d;
  logic [31:0] wacc_q, wacc_d;
  logic [2:0]  perr_q, perr_d;
  logic [7:0]  mtype_q, mtype_d;
  logic [31:0] pyi_q, pyi_d, pmask_q, pmask_d, prt_q, prt_d, psrv_q, psrv_d;
  logic [31:0] plse_q, plse_d;
  logic [3:0]  pseen_q, pseen_d;
  logic [31:0] ip_q, ip_d, mask_q, mask_d, gw_q, gw_d, srv_q, srv_d;
  logic [31:0] lease_q, lease_d, elap_q, elap_d;
  logic [31:0] renew_q, renew_d, rebind_q, rebind_d;
  logic [2:0]  arm_q, arm_d;

  logic        out_free;
  logic        take;

  // output register takes a new word when empty or being drained
  assign out_free   = !ov_q || !out_stall_i;
  assign in_stall_o = iv_q && !out_free;
  assign take       = iv_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xid_q <= '0;
    end else if (cfg_we_i) begin
      xid_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (!in_stall_o) begin
      iv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      iw_q <= in_data_i;
    end
  end

  // packet walk helpers
  function automatic logic [2:0] min_err(input logic [2:0] cur, input logic [2:0] code);
    min_err = (cur == ErrNone || code < cur) ? code : cur;
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic [15:0] o;
    logic [15:0] cnt;
    logic [1:0]  send;
    logic [2:0]  err;
    logic [7:0]  want;
    logic [31:0] acc;
    logic [34:0] t7;
    logic        clr;

    phase_d = phase_q;  off_d = off_q;  wpos_d = wpos_q;  wcode_d = wcode_q;
    wlen_d = wlen_q;  widx_d = widx_q;  wacc_d = wacc_q;  perr_d = perr_q;
    mtype_d = mtype_q;  pyi_d = pyi_q;  pmask_d = pmask_q;  prt_d = prt_q;
    psrv_d = psrv_q;  plse_d = plse_q;  pseen_d = pseen_q;
    ip_d = ip_q;  mask_d = mask_q;  gw_d = gw_q;  srv_d = srv_q;
    lease_d = lease_q;  elap_d = elap_q;  renew_d = renew_q;  rebind_d = rebind_q;
    arm_d = arm_q;
    b = iw_q.data_byte;  o = off_q;  send = SendNone;  err = ErrNone;
    want = '0;  acc = '0;  cnt = '0;  clr = 1'b0;
    t7 = '0;

    unique case (action_e'(iw_q.action))
      ActByte: begin
        if (o < 16'(MaxPayloadBytes)) begin
          if (o == 16'd0 && b != 8'd2) perr_d = min_err(perr_d, ErrOp);
          if (o >= 16'd4 && o <= 16'd7) begin
            want = xid_q[8*(3-o[1:0]) +: 8];
            if (b != want) perr_d = min_err(perr_d, ErrXid);
          end
          if (o >= 16'd16 && o <= 16'd19) pyi_d = {pyi_q[23:0], b};
          if (o >= 16'd236 && o <= 16'd239) begin
            want = Cookie[8*(3-o[1:0]) +: 8];
            if (b != want) perr_d = min_err(perr_d, ErrCookie);
          end
          if (o == 16'd240 && b != 8'd53) perr_d = min_err(perr_d, ErrFirst);
          if (o == 16'd242) mtype_d = b;
          if (o >= 16'd240) begin
            unique case (wpos_q)
              WkCode: begin
                if (b == 8'd255) wpos_d = WkDone;
                else if (b != 8'd0) begin
                  wcode_d = b;
                  wpos_d = WkLen;
                end
              end
              WkLen: begin
                wlen_d = b;  widx_d = '0;  wacc_d = '0;
                wpos_d = (b == 8'd0) ? WkCode : WkData;
              end
              WkData: begin
                if (widx_q < 8'd4) begin
                  acc = {wacc_q[23:0], b};
                  wacc_d = acc;
                  if (widx_q == 8'd3 && wlen_q >= 8'd4) begin
                    case (wcode_q)
                      8'd1:  begin pmask_d = acc; pseen_d[0] = 1'b1; end
                      8'd3:  begin prt_d = acc;   pseen_d[1] = 1'b1; end
                      8'd54: begin psrv_d = acc;  pseen_d[2] = 1'b1; end
                      8'd51: begin plse_d = acc;  pseen_d[3] = 1'b1; end
                      default: ;
                    endcase
                  end
                end
                // index stays below the length while in data, so it cannot wrap
                widx_d = widx_q + 8'd1;
                if (widx_d >= wlen_q) wpos_d = WkCode;
              end
              default: ;
            endcase
          end
        end
        cnt = (off_q != 16'hFFFF) ? off_q + 16'd1 : off_q;
        off_d = cnt;
        if (iw_q.last_byte) begin
          clr = 1'b1;
          if (cnt < 16'd243) err = ErrShort;
          else if (perr_d != ErrNone) err = perr_d;
          else if (mtype_d == 8'd2) begin
            if (phase_q == PhDisc) begin
              ip_d = pyi_d;
              if (pseen_d[2]) srv_d = psrv_d;
              phase_d = PhReq;
              send = SendRequest;
            end else begin
              err = ErrOffer;
            end
          end else if (mtype_d == 8'd5) begin
            ip_d = pyi_d;
            if (pseen_d[0]) mask_d = pmask_d;
            if (pseen_d[1]) gw_d = prt_d;
            if (pseen_d[2]) srv_d = psrv_d;
            lease_d = pseen_d[3] ? plse_d : 32'd0;
            elap_d = '0;
            t7 = {3'd0, lease_d} * 35'd7;
            renew_d = {1'b0, lease_d[31:1]};
            rebind_d = t7[34:3];
            if (lease_d != 32'd0) begin
              arm_d = 3'b111;
              phase_d = PhBound;
            end else begin
              arm_d = 3'b000;
            end
          end else if (mtype_d == 8'd6) begin
            arm_d = 3'b000;
            phase_d = PhDisc;
            send = SendDiscover;
          end else begin
            err = ErrType;
          end
        end
      end
      ActTick: begin
        if (arm_q != 3'b000) begin
          if (elap_q != 32'hFFFF_FFFF) elap_d = elap_q + 32'd1;
          if (arm_d[0] && elap_d >= renew_q) begin
            arm_d[0] = 1'b0;
            phase_d = PhRenew;
            send = SendRequest;
          end
          if (arm_d[1] && elap_d >= rebind_q) begin
            arm_d[1] = 1'b0;
            if (phase_d != PhBound) begin
              phase_d = PhRebind;
              send = SendRequest;
            end
          end
          if (arm_d[2] && elap_d >= lease_q) begin
            arm_d[2] = 1'b0;
            if (phase_d != PhBound) begin
              phase_d = PhDisc;
              arm_d = 3'b000;
              send = SendDiscover;
            end
          end
        end
      end
      ActStart: begin
        arm_d = 3'b000;
        phase_d = PhDisc;
        send = SendDiscover;
      end
      ActRelease: begin
        arm_d = 3'b000;
        phase_d = PhInit;
        send = SendRelease;
      end
      default: ;
    endcase

    if (clr) begin
      off_d = '0;  wpos_d = WkCode;  wcode_d = '0;  wlen_d = '0;  widx_d = '0;
      wacc_d = '0;  perr_d = ErrNone;  mtype_d = '0;  pyi_d = '0;  pmask_d = '0;
      prt_d = '0;  psrv_d = '0;  plse_d = '0;  pseen_d = '0;
    end

    ow_d.send_kind     = send;
    ow_d.phase         = phase_d;
    ow_d.error_code    = err;
    ow_d.ip_addr       = ip_d;
    ow_d.net_mask      = mask_d;
    ow_d.gateway_addr  = gw_d;
    ow_d.server_addr   = srv_d;
    ow_d.lease_seconds = lease_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhInit;  off_q <= '0;  wpos_q <= WkCode;  wcode_q <= '0;
      wlen_q <= '0;  widx_q <= '0;  wacc_q <= '0;  perr_q <= ErrNone;
      mtype_q <= '0;  pyi_q <= '0;  pmask_q <= '0;  prt_q <= '0;  psrv_q <= '0;
      plse_q <= '0;  pseen_q <= '0;  ip_q <= '0;  mask_q <= '0;  gw_q <= '0;
      srv_q <= '0;  lease_q <= '0;  elap_q <= '0;  renew_q <= '0;
      rebind_q <= '0;  arm_q <= '0;  ov_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d;  off_q <= off_d;  wpos_q <= wpos_d;  wcode_q <= wcode_d;
        wlen_q <= wlen_d;  widx_q <= widx_d;  wacc_q <= wacc_d;  perr_q <= perr_d;
        mtype_q <= mtype_d;  pyi_q <= pyi_d;  pmask_q <= pmask_d;  prt_q <= prt_d;
        psrv_q <= psrv_d;  plse_q <= plse_d;  pseen_q <= pseen_d;  ip_q <= ip_d;
        mask_q <= mask_d;  gw_q <= gw_d;  srv_q <= srv_d;  lease_q <= lease_d;
        elap_q <= elap_d;  renew_q <= renew_d;  rebind_q <= rebind_d;
        arm_q <= arm_d;
      end
      if (out_free) ov_q <= iv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) ow_q <= ow_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = ow_q;

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhRebind) else $error("phase out of range");
  a_armed_lease: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arm_q != 3'b000 |-> lease_q != 32'd0) else $error("timer armed without lease");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q && $stable(ow_q)) else $error("stalled result changed");
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !(iw_q.action == ActByte && iw_q.last_byte) |=> ow_q.error_code == ErrNone)
    else $error("error outside packet end");
endmodule
`default_nettype wire

/* bench/dhcp_client_lease_engine_top_test.sv */
// Self-checking bench for the DHCP client lease engine: random and directed reply packets,
// ticks and commands against an internal lease predictor. Depends on dhcp_lease_pkg.
`timescale 1ns / 100ps
module dhcp_client_lease_engine_top_test;
  import dhcp_lease_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;

  dhcp_client_lease_engine_top u_dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] xid_reg;
  logic [2:0] cl_phase;
  int unsigned rx_count;
  logic [1:0] wk_pos;
  logic [7:0] wk_code, wk_len;
  int unsigned wk_idx;
  logic [31:0] wk_acc;
  logic [2:0] pkt_err;
  logic [7:0] msg_type;
  logic [31:0] pend [5];
  logic [3:0] pend_seen;
  logic [31:0] addrs [4];
  logic [31:0] lease_tot, lease_el;
  logic [2:0] armed;

  in_word_t pending_words[$];
  out_word_t expected_words[$];
  int unsigned mismatches = 0;
  bit stim_done = 1'b0;
  bit hold_sender = 1'b0;

  function automatic void clear_reply();
    rx_count = 0; wk_pos = WkCode; wk_code = 0; wk_len = 0; wk_idx = 0; wk_acc = 0;
    pkt_err = ErrNone; msg_type = 0; pend_seen = 0;
    for (int i = 0; i < 5; i++) pend[i] = 0;
  endfunction

  function automatic void flag_error(logic [2:0] code);
    if (pkt_err == ErrNone || code < pkt_err) pkt_err = code;
  endfunction

  function automatic void walk_option(logic [7:0] b);
    case (wk_pos)
      WkCode: begin
        if (b == 8'd255) wk_pos = WkDone;
        else if (b != 0) begin
          wk_code = b; wk_pos = WkLen;
        end
      end
      WkLen: begin
        wk_len = b; wk_idx = 0; wk_acc = 0;
        wk_pos = (b == 0) ? WkCode : WkData;
      end
      WkData: begin
        if (wk_idx < 4) begin
          wk_acc = {wk_acc[23:0], b};
          if (wk_idx == 3 && wk_len >= 4) begin
            case (wk_code)
              8'd1: begin pend[1] = wk_acc; pend_seen[0] = 1'b1; end
              8'd3: begin pend[2] = wk_acc; pend_seen[1] = 1'b1; end
              8'd54: begin pend[3] = wk_acc; pend_seen[2] = 1'b1; end
              8'd51: begin pend[4] = wk_acc; pend_seen[3] = 1'b1; end
              default: ;
            endcase
          end
        end
        wk_idx++;
        if (wk_idx >= wk_len) wk_pos = WkCode;
      end
      default: ;
    endcase
  endfunction

  function automatic void absorb_byte(int unsigned o, logic [7:0] b);
    if (o == 0 && b != 8'd2) flag_error(ErrOp);
    if (o >= 4 && o <= 7 && b != xid_reg[(7 - o) * 8 +: 8]) flag_error(ErrXid);
    if (o >= 16 && o <= 19) pend[0] = {pend[0][23:0], b};
    if (o >= 236 && o <= 239 && b != Cookie[(239 - o) * 8 +: 8]) flag_error(ErrCookie);
    if (o == 240 && b != 8'd53) flag_error(ErrFirst);
    if (o == 242) msg_type = b;
    if (o >= 240) walk_option(b);
  endfunction

  function automatic void close_reply(output logic [2:0] err, inout logic [1:0] snd);
    err = ErrNone;
    if (rx_count < 243) err = ErrShort;
    else if (pkt_err != ErrNone) err = pkt_err;
    else if (msg_type == 8'd2) begin
      if (cl_phase == PhDisc) begin
        addrs[0] = pend[0];
        if (pend_seen[2]) addrs[3] = pend[3];
        cl_phase = PhReq; snd = SendRequest;
      end else err = ErrOffer;
    end else if (msg_type == 8'd5) begin
      addrs[0] = pend[0];
      if (pend_seen[0]) addrs[1] = pend[1];
      if (pend_seen[1]) addrs[2] = pend[2];
      if (pend_seen[2]) addrs[3] = pend[3];
      lease_tot = pend_seen[3] ? pend[4] : 0;
      lease_el = 0;
      if (lease_tot != 0) begin
        armed = 3'b111; cl_phase = PhBound;
      end else armed = 0;
    end else if (msg_type == 8'd6) begin
      armed = 0; cl_phase = PhDisc; snd = SendDiscover;
    end else err = ErrType;
    clear_reply();
  endfunction

  function automatic void run_tick(inout logic [1:0] snd);
    logic [31:0] renew_at, rebind_at;
    logic [34:0] prod;
    renew_at = lease_tot >> 1;
    prod = lease_tot * 35'd7;
    rebind_at = prod[34:3];
    if (armed == 0) return;
    if (lease_el != 32'hFFFF_FFFF) lease_el++;
    if (armed[0] && lease_el >= renew_at) begin
      armed[0] = 0; cl_phase = PhRenew; snd = SendRequest;
    end
    if (armed[1] && lease_el >= rebind_at) begin
      armed[1] = 0;
      if (cl_phase != PhBound) begin
        cl_phase = PhRebind; snd = SendRequest;
      end
    end
    if (armed[2] && lease_el >= lease_tot) begin
      armed[2] = 0;
      if (cl_phase != PhBound) begin
        cl_phase = PhDisc; armed = 0; snd = SendDiscover;
      end
    end
  endfunction

  function automatic out_word_t predict_lease(in_word_t w);
    out_word_t r;
    logic [1:0] snd;
    logic [2:0] err;
    snd = SendNone; err = ErrNone;
    case (action_e'(w.action))
      ActByte: begin
        if (rx_count < MaxPayloadBytes) absorb_byte(rx_count, w.data_byte);
        if (rx_count < 65535) rx_count++;
        if (w.last_byte) close_reply(err, snd);
      end
      ActTick: run_tick(snd);
      ActStart: begin armed = 0; cl_phase = PhDisc; snd = SendDiscover; end
      default: begin armed = 0; cl_phase = PhInit; snd = SendRelease; end
    endcase
    r.send_kind = snd; r.phase = cl_phase; r.error_code = err;
    r.ip_addr = addrs[0]; r.net_mask = addrs[1]; r.gateway_addr = addrs[2];
    r.server_addr = addrs[3]; r.lease_seconds = lease_tot;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(3, 0) != 0) return 0;
    if ($urandom_range(9, 0) != 0) return $urandom_range(3, 1);
    return $urandom_range(30, 5);
  endfunction

  // record acceptance at the rising edge, before the block updates its stall
  bit in_taken = 1'b0;
  always @(posedge clk) in_taken = in_valid && !in_stall;

  // driver
  int unsigned send_gap = 0;
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (in_valid) expected_words.push_back(predict_lease(in_data));
      if (send_gap != 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0 && !hold_sender) begin
        in_data <= pending_words.pop_front();
        in_valid <= 1'b1;
        send_gap = pick_gap();
      end else in_valid <= 1'b0;
    end
  end

  // stall generator
  int unsigned stall_gap = 0;
  always @(negedge clk) begin
    if (stall_gap != 0) begin
      stall_gap--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_gap = pick_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_data);
      end else begin
        want = expected_words.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("word mismatch: expected %h got %h", want, out_data);
        end
      end
    end
  end

  // reply builder
  function automatic void queue_reply(logic [31:0] xid, logic [7:0] mtype, int unsigned len,
                                      int unsigned corrupt, logic [31:0] lease);
    logic [7:0] pkt [];
    int unsigned p;
    pkt = new[len < 300 ? 300 : len];
    foreach (pkt[i]) pkt[i] = $urandom_range(255, 0);
    pkt[0] = 8'd2;
    for (int i = 0; i < 4; i++) begin
      pkt[4 + i] = xid[(3 - i) * 8 +: 8];
      pkt[236 + i] = Cookie[(3 - i) * 8 +: 8];
    end
    pkt[240] = 8'd53; pkt[241] = 8'd1; pkt[242] = mtype;
    p = 243;
    while (p + 6 < pkt.size() && $urandom_range(4, 0) != 0) begin
      case ($urandom_range(7, 0))
        0: pkt[p] = 8'd1;
        1: pkt[p] = 8'd3;
        2: pkt[p] = 8'd54;
        3, 4: pkt[p] = 8'd51;
        5: pkt[p] = 8'd0;
        default: pkt[p] = $urandom_range(255, 0);
      endcase
      if (pkt[p] == 8'd0) begin
        p++;
        continue;
      end
      pkt[p + 1] = ($urandom_range(3, 0) == 0) ? $urandom_range(5, 0) : 8'd4;
      if (pkt[p] == 8'd51) for (int i = 0; i < 4; i++) pkt[p + 2 + i] = lease[(3 - i) * 8 +: 8];
      p += 2 + pkt[p + 1];
    end
    if (p < pkt.size()) pkt[p] = 8'd255;
    case (corrupt)
      1: pkt[237] ^= 8'h10;
      2: pkt[0] = 8'd1;
      3: pkt[6] ^= 8'h01;
      4: pkt[240] = 8'd12;
      default: ;
    endcase
    for (int i = 0; i < len; i++) begin
      in_word_t w;
      w.action = ActByte; w.data_byte = pkt[i]; w.last_byte = (i == len - 1);
      pending_words.push_back(w);
      if ($urandom_range(40, 0) == 0) begin
        w.action = action_e'($urandom_range(1, 0) ? ActTick : $urandom_range(3, 2));
        w.data_byte = $urandom_range(255, 0); w.last_byte = $urandom_range(1, 0);
        pending_words.push_back(w);
      end
    end
  endfunction

  function automatic void queue_cmd(action_e a);
    in_word_t w;
    w.action = a; w.data_byte = $urandom_range(255, 0); w.last_byte = $urandom_range(1, 0);
    pending_words.push_back(w);
  endfunction

  task automatic drain();
    while (pending_words.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic set_xid(logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    xid_reg = v;
  endtask

  function automatic logic [31:0] small_lease();
    return ($urandom_range(5, 0) == 0) ? $urandom : $urandom_range(12, 1);
  endfunction

  initial begin
    int unsigned words_sent;
    logic [31:0] xids [3];
    xid_reg = 0; cl_phase = PhInit; lease_tot = 0; lease_el = 0; armed = 0;
    for (int i = 0; i < 4; i++) addrs[i] = 0;
    clear_reply();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    xids[0] = 32'h0; xids[1] = 32'hFFFF_FFFF; xids[2] = $urandom;
    for (int ph = 0; ph < 3; ph++) begin
      set_xid(xids[ph]);
      if (ph == 0) begin
        // directed: commands, offer taken, ack with a short lease and its timers
        queue_cmd(ActTick); queue_cmd(ActRelease); queue_cmd(ActStart);
        queue_reply(xid_reg, 8'd2, 250, 0, 0);
        queue_reply(xid_reg, 8'd5, 262, 0, 32'd4);
        for (int i = 0; i < 5; i++) queue_cmd(ActTick);
      end else if (ph == 1) begin
        queue_reply(xid_reg, $urandom_range(1, 0) ? 8'd2 : 8'd5, 256,
                    $urandom_range(4, 0), small_lease());
      end else begin
        // nak, then a reply cut short
        queue_reply(xid_reg, 8'd6, 243, 0, 0);
        queue_reply(xid_reg, 8'd5, 1, 0, 0);
      end
      words_sent = 0;
      while (words_sent < 12) begin
        words_sent++;
        if ($urandom_range(4, 0) != 0) repeat ($urandom_range(8, 1)) queue_cmd(ActTick);
        else queue_cmd(action_e'($urandom_range(3, 2)));
        if (words_sent == 6 && ph == 1) begin
          hold_sender = 1'b1;
          while (in_valid || expected_words.size() != 0) @(posedge clk);
          hold_sender = 1'b0;
        end
      end
      drain();
    end
    stim_done = 1'b1;
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
